@@ rtl/core/de_bruijn_sequence_generator_macros.svh @@
// Assertion macros for the De Bruijn sequence generator checker.
// Included by the checker file only; needs no other file.
`ifndef DE_BRUIJN_SEQUENCE_GENERATOR_MACROS_SVH
`define DE_BRUIJN_SEQUENCE_GENERATOR_MACROS_SVH

// Property checked on every rising edge, ignored while reset is active.
`define DBSG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define DBSG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dbsg_pkg.sv @@
// Shared types and constants of the De Bruijn sequence generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package dbsg_pkg;

  localparam int SYMBOL_W   = 8;
  localparam int SYMCNT_W   = 9;
  localparam int ORDER_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER        = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic emit;       // transfer accepted: present the next symbol
    logic prep;       // start a successor step: load p and the copy index
    logic ext_sel;    // read address follows the copy index (i - p)
    logic ext_step;   // copy one symbol of the periodic extension
    logic scan_sel;   // read address follows the scan index (i - 1)
    logic scan_dec;   // symbol at i - 1 is maximal: move down
    logic scan_bump;  // increment the symbol at i - 1 and set the new length
    logic scan_wrap;  // no symbol left to increment: back to the all-zero word
    logic div_step;   // one subtraction of the divisibility test
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_hit;    // a write to a defined register this cycle
    logic out_free;   // output register empty or being taken
    logic wrap;       // the symbol being emitted closes the current word
    logic ext_done;   // extension reached the order
    logic scan_zero;  // scan index reached zero
    logic scan_max;   // symbol under the scan index is the largest one
    logic rem_ge;     // remainder still at least the word length
    logic rem_zero;   // remainder is zero
  } stat_t;

endpackage

@@ rtl/core/dbsg_controller.sv @@
// Sequencer of the De Bruijn sequence generator: emit, extend, scan, divide.
// Depends on dbsg_pkg for the command and status structs.
module dbsg_controller (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dbsg_pkg::stat_t stat,
  output dbsg_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_EXTEND = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_DIV    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = !((state_r == ST_IDLE) && stat.out_free && !stat.cfg_hit);
    if (stat.cfg_hit) begin
      state_nxt = ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd.emit = 1'b1;
            if (stat.wrap) begin
              state_nxt = ST_PREP;
            end
          end
        end
        ST_PREP: begin
          cmd.prep  = 1'b1;
          state_nxt = ST_EXTEND;
        end
        ST_EXTEND: begin
          cmd.ext_sel = 1'b1;
          if (stat.ext_done) begin
            state_nxt = ST_SCAN;
          end else begin
            cmd.ext_step = 1'b1;
          end
        end
        ST_SCAN: begin
          cmd.scan_sel = 1'b1;
          if (stat.scan_zero) begin
            cmd.scan_wrap = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (stat.scan_max) begin
            cmd.scan_dec = 1'b1;
          end else begin
            cmd.scan_bump = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
        ST_DIV: begin
          if (stat.rem_ge) begin
            cmd.div_step = 1'b1;
          end else if (stat.rem_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PREP;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/dbsg_datapath.sv @@
// Datapath of the De Bruijn sequence generator: word store, counters,
// configuration registers and output register. Depends on dbsg_pkg.
module dbsg_datapath #(
  parameter int MAX_SYMBOLS = 256,
  parameter int MAX_ORDER   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dbsg_pkg::cmd_t                      cmd,
  output dbsg_pkg::stat_t                     stat,
  input  logic                                cfg_we,
  input  logic [dbsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbsg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dbsg_pkg::SYMBOL_W-1:0]       out_symbol,
  output logic                                out_cycle_end
);

  localparam int SW  = dbsg_pkg::SYMBOL_W;
  localparam int KW  = dbsg_pkg::SYMCNT_W;
  localparam int NW  = dbsg_pkg::ORDER_W;
  localparam int CW  = $clog2(MAX_ORDER + 1);
  localparam int IW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic [SW-1:0] word_r [MAX_ORDER];
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [KW-1:0] k_r;
  logic [NW-1:0] n_r;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_symbol_r;
  logic          out_cycle_end_r;

  logic [KW-1:0] k_eff, k_less;
  logic [SW-1:0] k_top;
  logic [31:0]   n_wide, n_sel;
  logic [CW-1:0] n_eff;
  logic          len_bad, restart_eff, wrap_e, end_e;
  logic [CW-1:0] pos_e, len_e, pos_inc, rd_idx;
  logic [SW-1:0] rd_data, sym_e;
  logic          wr_en, clr;
  logic [CW-1:0] wr_idx;
  logic [SW-1:0] wr_data;

  // Clamped alphabet size and order.
  always_comb begin
    if (k_r < KW'(2)) begin
      k_eff = KW'(2);
    end else if (k_r > KW'(MAX_SYMBOLS)) begin
      k_eff = KW'(MAX_SYMBOLS);
    end else begin
      k_eff = k_r;
    end
    k_less = k_eff - KW'(1);
    k_top  = k_less[SW-1:0];
    n_wide = 32'(n_r);
    if (n_r == '0) begin
      n_sel = 32'd1;
    end else if (n_wide > 32'(MAX_ORDER)) begin
      n_sel = 32'(MAX_ORDER);
    end else begin
      n_sel = n_wide;
    end
    n_eff = n_sel[CW-1:0];
  end

  assign stat.cfg_hit = cfg_we &&
                        ((cfg_index == dbsg_pkg::REG_SYMBOL_COUNT) ||
                         (cfg_index == dbsg_pkg::REG_ORDER));

  // Emit path: the model's sanity checks on the stored length and position.
  always_comb begin
    len_bad     = (len_r == '0) || (len_r > n_eff);
    restart_eff = in_restart || len_bad;
    pos_e       = (restart_eff || (pos_r >= len_r)) ? '0 : pos_r;
    len_e       = restart_eff ? CW'(1) : len_r;
    if (cmd.ext_sel) begin
      rd_idx = i_r - p_r;
    end else if (cmd.scan_sel) begin
      rd_idx = i_r - CW'(1);
    end else begin
      rd_idx = pos_e;
    end
    rd_data = word_r[rd_idx[IW-1:0]];
    sym_e   = restart_eff ? '0 : rd_data;
    pos_inc = pos_e + CW'(1);
    wrap_e  = (pos_inc >= len_e);
    end_e   = wrap_e && (len_e == CW'(1)) && (sym_e == k_top);
  end

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.wrap      = wrap_e;
  assign stat.ext_done  = (i_r >= n_eff);
  assign stat.scan_zero = (i_r == '0);
  assign stat.scan_max  = (rd_data >= k_top);
  assign stat.rem_ge    = (rem_r >= len_r);
  assign stat.rem_zero  = (rem_r == '0);

  always_comb begin
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    wr_en         = 1'b0;
    wr_idx        = i_r;
    wr_data       = rd_data;
    clr           = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.cfg_hit) begin
      clr     = 1'b1;
      len_nxt = CW'(1);
      pos_nxt = '0;
    end else begin
      if (cmd.emit) begin
        clr           = restart_eff;
        len_nxt       = len_e;
        pos_nxt       = wrap_e ? '0 : pos_inc;
        out_valid_nxt = 1'b1;
      end
      if (cmd.prep) begin
        p_nxt = len_bad ? CW'(1) : len_r;
        i_nxt = len_bad ? CW'(1) : len_r;
      end
      if (cmd.ext_step) begin
        wr_en = 1'b1;
        wr_idx = i_r;
        i_nxt = i_r + CW'(1);
      end
      if (cmd.scan_dec) begin
        i_nxt = i_r - CW'(1);
      end
      if (cmd.scan_bump) begin
        wr_en   = 1'b1;
        wr_idx  = i_r - CW'(1);
        wr_data = rd_data + SW'(1);
        len_nxt = i_r;
        rem_nxt = n_eff;
      end
      if (cmd.scan_wrap) begin
        clr     = 1'b1;
        len_nxt = CW'(1);
        pos_nxt = '0;
      end
      if (cmd.div_step) begin
        rem_nxt = rem_r - len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int j = 0; j < MAX_ORDER; j++) begin
        word_r[j] <= '0;
      end
    end else if (wr_en) begin
      word_r[wr_idx[IW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= CW'(1);
      pos_r       <= '0;
      k_r         <= KW'(2);
      n_r         <= NW'(3);
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == dbsg_pkg::REG_SYMBOL_COUNT)) begin
        k_r <= cfg_wdata[KW-1:0];
      end
      if (cfg_we && (cfg_index == dbsg_pkg::REG_ORDER)) begin
        n_r <= cfg_wdata[NW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    p_r   <= p_nxt;
    rem_r <= rem_nxt;
    if (cmd.emit && !stat.cfg_hit) begin
      out_symbol_r    <= sym_e;
      out_cycle_end_r <= end_e;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_symbol    = out_symbol_r;
  assign out_cycle_end = out_cycle_end_r;

endmodule

@@ rtl/core/de_bruijn_sequence_generator.sv @@
// Top level of the De Bruijn sequence generator B(k,n).
// Instantiates dbsg_controller and dbsg_datapath; uses dbsg_pkg.
//
// Usage: every transfer on the input channel (in_valid, in_stall, in_restart)
// yields exactly one transfer on the output channel (out_valid, out_stall,
// out_symbol, out_cycle_end). The symbols, taken in order, form the cyclic
// De Bruijn sequence of alphabet size k and order n; out_cycle_end marks the
// last symbol of each k^n cycle, and the next symbol starts the cycle again.
// Setting in_restart goes back to the all-zero word before the symbol is taken.
// The symbol is in the output register in the cycle after the input transfer.
// Inside a Lyndon word a new input transfer is taken whenever the output
// register is free. When a symbol closes a word, the sequencer searches for
// the next emitted word: each successor step copies the periodic extension
// up to order n, moves down over trailing maximal symbols and bumps the last
// one left, then tests whether its length divides n (no test when the walk
// wraps); steps repeat over skipped words; the input is stalled meanwhile.
// A finished symbol waiting in the output register does not hold the search;
// only the next input transfer waits for a free output register.
// Reset (synchronous, rst_n low) sets k = 2, n = 3 and the all-zero word.
// A write to either configuration register also restarts the sequence.
module de_bruijn_sequence_generator #(
  parameter int MAX_SYMBOLS = 256,
  parameter int MAX_ORDER   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dbsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbsg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dbsg_pkg::SYMBOL_W-1:0]       out_symbol,
  output logic                                out_cycle_end
);

  dbsg_pkg::cmd_t  cmd;
  dbsg_pkg::stat_t stat;

  // The controller owns the sequencing; it also decides when the input
  // channel may transfer.
  dbsg_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the current Lyndon word, the configuration registers
  // and the output register.
  dbsg_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .MAX_ORDER   (MAX_ORDER)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_symbol    (out_symbol),
    .out_cycle_end (out_cycle_end)
  );

endmodule

@@ rtl/core/dbsg_checker.sv @@
// Port-level checker for the De Bruijn sequence generator, bound to the top.
// Depends on dbsg_pkg and de_bruijn_sequence_generator_macros.svh.
`include "de_bruijn_sequence_generator_macros.svh"

module dbsg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_restart,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [dbsg_pkg::SYMBOL_W-1:0]       out_symbol,
  input logic                                out_cycle_end
);

  // A stalled result holds until it is taken.
  `DBSG_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_symbol) && $stable(out_cycle_end)), "stalled output changed")

  // Every input transfer shows a result in the next cycle.
  `DBSG_ASSERT(a_accept_result, clk, rst_n, (in_valid && !in_stall) |=> out_valid, "input transfer without a result")

  // A restart always begins with symbol zero, which never closes a cycle.
  `DBSG_ASSERT(a_restart_zero, clk, rst_n, (in_valid && !in_stall && in_restart) |=> (out_valid && (out_symbol == '0) && !out_cycle_end), "restart did not emit symbol zero")

  // Reset empties the output register.
  `DBSG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind de_bruijn_sequence_generator dbsg_checker u_dbsg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_restart    (in_restart),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_symbol    (out_symbol),
  .out_cycle_end (out_cycle_end)
);

@@ test/de_bruijn_sequence_generator_tb.sv @@
// Self-checking testbench for the De Bruijn sequence generator B(k,n).
// Needs dbsg_pkg and de_bruijn_sequence_generator; a directed table is followed by
// random phases over many alphabet/order settings, checked by a predictor or typed rows.
module de_bruijn_sequence_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYMBOL_W   = dbsg_pkg::SYMBOL_W;
  localparam int SYMCNT_W   = dbsg_pkg::SYMCNT_W;
  localparam int ORDER_W    = dbsg_pkg::ORDER_W;
  localparam int CFG_IDX_W  = dbsg_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = dbsg_pkg::CFG_DATA_W;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam int LW_MAX_SYMBOLS = 256;
  localparam int LW_MAX_ORDER   = 16;

  // The search for the next emitted word can go on after the last symbol has
  // been taken, so the bench waits this long before touching the registers.
  localparam int SETTLE_CYCLES = 2000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_PHASES   = 12;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                cycle_end;
  } seq_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: either an input transfer or a register write.
  // Rows with typed set carry an expectation written out by hand.
  typedef struct packed {
    row_kind_t             kind;
    logic                  restart;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  typed;
    logic [SYMBOL_W-1:0]   want_symbol;
    logic                  want_end;
  } dir_row_t;

  localparam int DIR_ROWS = 35;

  dir_row_t dir_table [DIR_ROWS] = '{
    // Reset setting k = 2, n = 3: one full cycle 0001 0111, then it wraps.
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd1, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd1, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd1, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd1, 1'b1},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    // Restart between two words.
    '{ROW_ITEM, 1'b1, '0, '0, 1'b1, 8'd0, 1'b0},
    // Order 1 gives the two-symbol cycle 0 1.
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_ORDER, 9'd1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd1, 1'b1},
    // Order 0 is taken as 1.
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_ORDER, 9'd0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    // Alphabet sizes 0 and 1 are taken as 2.
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_SYMBOL_COUNT, 9'd0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd1, 1'b1},
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_SYMBOL_COUNT, 9'd1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b1, 8'd0, 1'b0},
    // Writes past the register list change nothing and do not restart.
    '{ROW_CFG,  1'b0, REG_UNUSED_2, 9'h1FF, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_CFG,  1'b0, REG_UNUSED_3, 9'h000, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0},
    // All-ones data: alphabet clamps to 256, order is masked to 31 then clamps to 16.
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_SYMBOL_COUNT, 9'h1FF, 1'b0, '0, 1'b0},
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_ORDER, 9'h1FF, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b1, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0},
    // Largest legal settings written exactly.
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_SYMBOL_COUNT, 9'd256, 1'b0, '0, 1'b0},
    '{ROW_CFG,  1'b0, dbsg_pkg::REG_ORDER, 9'd16, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, 1'b0, '0, '0, 1'b0, '0, 1'b0}
  };

  // Settings of the first random phases; the last two are drawn at random.
  int rnd_k [10] = '{2, 3, 2, 4, 256, 256, 17, 2, 200, 7};
  int rnd_n [10] = '{1, 2, 4, 2, 1,   2,   3,  16, 16, 3};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_restart;
  logic                  out_valid;
  logic                  out_stall;
  logic [SYMBOL_W-1:0]   out_symbol;
  logic                  out_cycle_end;

  // Predictor state: the alphabet and order registers and the current Lyndon word.
  logic [SYMCNT_W-1:0] alpha_reg;
  logic [ORDER_W-1:0]  order_reg;
  logic [SYMBOL_W-1:0] lw_word [LW_MAX_ORDER];
  logic [4:0]          lw_len;
  logic [4:0]          lw_pos;

  seq_out_t pending_symbols [$];

  int  fail_count;
  int  items_sent;
  int  restarts_sent;
  int  results_checked;
  int  cycle_ends_seen;
  int  cycle_count;
  int  idle_pct;
  bit  items_since_settle;

  always #1 clk = ~clk;

  de_bruijn_sequence_generator u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_symbol   (out_symbol),
    .out_cycle_end(out_cycle_end)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void lyndon_clear();
    foreach (lw_word[j]) lw_word[j] = '0;
    lw_len = 5'd1;
    lw_pos = 5'd0;
  endfunction

  // Moves to the next Lyndon word of length at most n in lexicographic order:
  // extend the word periodically to length n, drop trailing maximal symbols
  // and bump the last one left. When every symbol is maximal the walk wraps.
  function automatic void lyndon_next(input int k, input int n);
    int p;
    int i;
    p = lw_len;
    if (p < 1 || p > n) p = 1;
    for (i = p; i < n; i++) lw_word[i] = lw_word[i - p];
    i = n;
    while (i > 0 && int'(lw_word[i - 1]) >= k - 1) i--;
    if (i == 0) begin
      lyndon_clear();
    end else begin
      lw_word[i - 1] = lw_word[i - 1] + 1'b1;
      lw_len = 5'(i);
    end
  endfunction

  // Produces the symbol that one input transfer yields and advances the walk.
  // Only words whose length divides n take part in the sequence.
  function automatic seq_out_t predict_symbol(input logic restart);
    int       k;
    int       n;
    seq_out_t res;
    k = int'(alpha_reg);
    if (k < 2) k = 2;
    if (k > LW_MAX_SYMBOLS) k = LW_MAX_SYMBOLS;
    n = int'(order_reg);
    if (n < 1) n = 1;
    if (n > LW_MAX_ORDER) n = LW_MAX_ORDER;
    if (restart) lyndon_clear();
    if (lw_len < 1 || int'(lw_len) > n) lyndon_clear();
    if (lw_pos >= lw_len) lw_pos = '0;
    res.symbol = lw_word[lw_pos];
    res.cycle_end = 1'b0;
    lw_pos = lw_pos + 1'b1;
    if (lw_pos >= lw_len) begin
      // The single word holding the largest symbol closes the k^n cycle.
      res.cycle_end = (lw_len == 5'd1) && (int'(lw_word[0]) == k - 1);
      lw_pos = '0;
      do begin
        lyndon_next(k, n);
      end while ((n % int'(lw_len)) != 0);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
             $realtime, what, got, want, results_checked);
    fail_count++;
  endtask

  function automatic int idle_length();
    int r;
    if (idle_pct == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 2) return $urandom_range(15, 40);
    if (r < idle_pct) return $urandom_range(1, 3);
    return 0;
  endfunction

  // A register write takes effect at the next rising edge. When another write
  // follows right away the enable simply stays high.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit more);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == dbsg_pkg::REG_SYMBOL_COUNT) begin
      alpha_reg = data;
      lyndon_clear();
    end else if (idx == dbsg_pkg::REG_ORDER) begin
      order_reg = data[ORDER_W-1:0];
      lyndon_clear();
    end
    if (!more) cfg_we <= 1'b0;
  endtask

  // Before a register write: stop offering, let every expected symbol come
  // back, then give the successor search time to finish.
  task automatic quiesce();
    if (items_since_settle) begin
      in_valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      items_since_settle = 1'b0;
    end
  endtask

  // Offers one transfer and holds it until accepted. The expectation is pushed
  // at the accepting edge; valid stays high unless an idle gap follows.
  task automatic send_item(input logic restart, input bit typed, input seq_out_t want);
    seq_out_t predicted;
    int       gap;
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    predicted = predict_symbol(restart);
    pending_symbols.push_back(typed ? want : predicted);
    items_sent++;
    if (restart) restarts_sent++;
    items_since_settle = 1'b1;
    gap = idle_length();
    if (gap > 0) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : rx_side
    seq_out_t want;
    int       r;
    static int stall_left = 0;
    static bit hold_done  = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch("unexpected transfer, symbol", out_symbol, -1);
      end else begin
        want = pending_symbols.pop_front();
        if (out_symbol !== want.symbol)
          report_mismatch("symbol", out_symbol, want.symbol);
        if (out_cycle_end !== want.cycle_end)
          report_mismatch("cycle_end", out_cycle_end, want.cycle_end);
        if (want.cycle_end) cycle_ends_seen++;
      end
      results_checked++;
    end
    // One long hold-off while the sender keeps going, so the block backs up
    // into its input channel.
    if (!hold_done && results_checked >= HOLD_AT) begin
      hold_done  = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left == 0 && idle_pct > 0) begin
      r = $urandom_range(0, 99);
      if (r < 2) stall_left = $urandom_range(15, 40);
      else if (r < idle_pct) stall_left = $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d symbols still expected",
               cycle_count, pending_symbols.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int       ph;
    int       i;
    int       k_val;
    int       n_val;
    int       count;
    seq_out_t want;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    out_stall  <= 1'b0;
    fail_count = 0;
    items_sent = 0;
    restarts_sent = 0;
    results_checked = 0;
    cycle_ends_seen = 0;
    cycle_count = 0;
    idle_pct = 25;
    items_since_settle = 1'b0;
    alpha_reg = 9'd2;
    order_reg = 5'd3;
    lyndon_clear();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Register rows drain the block first; consecutive
    // register rows keep the write enable high between them.
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        quiesce();
        cfg_write(dir_table[i].cfg_idx, dir_table[i].cfg_data,
                  i + 1 < DIR_ROWS && dir_table[i + 1].kind == ROW_CFG);
      end else begin
        want.symbol    = dir_table[i].want_symbol;
        want.cycle_end = dir_table[i].want_end;
        send_item(dir_table[i].restart, dir_table[i].typed, want);
      end
    end

    // Random phases. Every fourth phase runs with no idling on either side.
    // Restarts are rare so that long stretches of the sequence are walked.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 10) begin
        k_val = rnd_k[ph];
        n_val = rnd_n[ph];
      end else begin
        k_val = $urandom_range(0, 511);
        n_val = $urandom_range(0, 31);
      end
      quiesce();
      idle_pct = (ph % 4 == 3) ? 0 : 25;
      cfg_write(dbsg_pkg::REG_SYMBOL_COUNT, CFG_DATA_W'(k_val), 1'b1);
      cfg_write(dbsg_pkg::REG_ORDER, CFG_DATA_W'(n_val), ph == 6);
      if (ph == 6) cfg_write(REG_UNUSED_3, CFG_DATA_W'($urandom_range(0, 511)), 1'b0);
      // A one-symbol alphabet word per step needs 256 transfers per cycle.
      count = (k_val == 256 && n_val == 1) ? 300 : 95;
      for (i = 0; i < count; i++) begin
        if (ph == 5 && i == 40) begin
          // Sender pause until the block has handed back everything.
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_symbols.size() != 0);
        end
        send_item($urandom_range(0, 99) < 3, 1'b0, want);
      end
    end

    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d symbols from %0d transfers (%0d with restart), %0d cycle ends,",
             results_checked, items_sent, restarts_sent, cycle_ends_seen);
    $display("over %0d random alphabet/order settings plus the directed table.",
             RAND_PHASES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/dbsg_pkg.sv
rtl/core/dbsg_controller.sv
rtl/core/dbsg_datapath.sv
rtl/core/de_bruijn_sequence_generator.sv
rtl/core/dbsg_checker.sv
test/de_bruijn_sequence_generator_tb.sv
